// ----- rtl/core/xss_pkg.sv -----
package xss_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;

   // command codes carried on req_tuser
   localparam logic CMD_RESEED = 1'b0;
   localparam logic CMD_NEXT   = 1'b1;

   localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d049bb133111eb;

   localparam int ADV_SHIFT = 17;

   // partial-product steps of the 64 x 64 (mod 2^64) constant multiply
   localparam logic [1:0] MUL_LO_LO = 2'd0;
   localparam logic [1:0] MUL_LO_HI = 2'd1;
   localparam logic [1:0] MUL_HI_LO = 2'd2;

   localparam logic [1:0] LAST_WORD = 2'd3;

   typedef struct packed {
      logic       load_seed;
      logic       advance;
      logic       draw;
      logic       mix_b;
      logic       mul_en;
      logic       mul_sel_b;
      logic [1:0] mul_step;
      logic       store;
      logic [1:0] word_idx;
   } dp_cmd_type;

   function automatic logic [WORD_W-1:0] rotl7(input logic [WORD_W-1:0] v);
      rotl7 = {v[WORD_W-8:0], v[WORD_W-1:WORD_W-7]};
   endfunction

   function automatic logic [WORD_W-1:0] rotl45(input logic [WORD_W-1:0] v);
      rotl45 = {v[WORD_W-46:0], v[WORD_W-1:WORD_W-45]};
   endfunction

endpackage

// ----- rtl/core/xss_dp.sv -----
module xss_dp
   import xss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   input  logic [WORD_W-1:0] seed,
   output logic [WORD_W-1:0] rsp_data
);

   logic [WORD_W-1:0] words_ff [4];
   logic [WORD_W-1:0] counter_ff;
   logic [WORD_W-1:0] z_ff;
   logic [WORD_W-1:0] acc_ff;
   logic [WORD_W-1:0] rsp_data_ff;

   logic [WORD_W-1:0] counter_in;
   logic [WORD_W-1:0] acc_in;
   logic [WORD_W-1:0] rsp_data_in;

   logic [WORD_W-1:0] mul_const;
   logic [HALF_W-1:0] mul_a;
   logic [HALF_W-1:0] mul_b;
   logic [WORD_W-1:0] mul_prod;

   logic [WORD_W-1:0] n0, n1, n2, n3, shifted;
   logic [WORD_W-1:0] times5, rot, times9;
   logic [WORD_W-1:0] mix_out;

   // xoshiro256** output and state update
   always_comb begin
      times5  = words_ff[1] + {words_ff[1][WORD_W-3:0], 2'b00};
      rot     = rotl7(times5);
      times9  = rot + {rot[WORD_W-4:0], 3'b000};
      shifted = {words_ff[1][WORD_W-1-ADV_SHIFT:0], {ADV_SHIFT{1'b0}}};
      n2      = words_ff[2] ^ words_ff[0];
      n3      = words_ff[3] ^ words_ff[1];
      n1      = words_ff[1] ^ n2;
      n0      = words_ff[0] ^ n3;
   end

   assign rsp_data_in = cmd.advance ? times9 : rsp_data_ff;
   assign counter_in  = counter_ff + GOLDEN_GAMMA;
   assign mix_out     = acc_ff ^ (acc_ff >> 31);

   // one 32 x 32 partial product per cycle
   always_comb begin
      mul_const = cmd.mul_sel_b ? MIX_MUL_B : MIX_MUL_A;
      mul_a     = (cmd.mul_step == MUL_HI_LO) ? z_ff[WORD_W-1:HALF_W] : z_ff[HALF_W-1:0];
      mul_b     = (cmd.mul_step == MUL_LO_HI) ? mul_const[WORD_W-1:HALF_W]
                                              : mul_const[HALF_W-1:0];
      mul_prod  = WORD_W'(mul_a) * WORD_W'(mul_b);
      if (cmd.mul_step == MUL_LO_LO) begin
         acc_in = mul_prod;
      end else begin
         acc_in = acc_ff + {mul_prod[HALF_W-1:0], {HALF_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            words_ff[i] <= '0;
         end
         counter_ff <= '0;
      end else begin
         if (cmd.load_seed) begin
            counter_ff <= seed;
         end else if (cmd.draw) begin
            counter_ff <= counter_in;
         end
         if (cmd.advance) begin
            words_ff[0] <= n0;
            words_ff[1] <= n1;
            words_ff[2] <= n2 ^ shifted;
            words_ff[3] <= rotl45(n3);
         end else if (cmd.store) begin
            words_ff[cmd.word_idx] <= mix_out;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.draw) begin
         z_ff <= counter_in ^ (counter_in >> 30);
      end else if (cmd.mix_b) begin
         z_ff <= acc_ff ^ (acc_ff >> 27);
      end
      if (cmd.mul_en) begin
         acc_ff <= acc_in;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ----- rtl/core/xss_ctrl.sv -----
module xss_ctrl
   import xss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_cmd,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DRAW  = 6'b000010,
      ST_MUL_A = 6'b000100,
      ST_MIX_B = 6'b001000,
      ST_MUL_B = 6'b010000,
      ST_STORE = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] step_ff, step_in;
   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      cmd           = '0;
      cmd.mul_step  = step_ff;
      cmd.word_idx  = idx_ff;
      rsp_valid_in  = rsp_tready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_RESEED) begin
                  cmd.load_seed = 1'b1;
                  idx_in        = '0;
                  state_in      = ST_DRAW;
               end else begin
                  cmd.advance  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_DRAW: begin
            cmd.draw = 1'b1;
            step_in  = MUL_LO_LO;
            state_in = ST_MUL_A;
         end
         ST_MUL_A: begin
            cmd.mul_en = 1'b1;
            if (step_ff == MUL_HI_LO) begin
               step_in  = MUL_LO_LO;
               state_in = ST_MIX_B;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_MIX_B: begin
            cmd.mix_b = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel_b = 1'b1;
            if (step_ff == MUL_HI_LO) begin
               step_in  = MUL_LO_LO;
               state_in = ST_STORE;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (idx_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_DRAW;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_reseed_starts_draw: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_RESEED) |=> state_ff == ST_DRAW)
      else $error("reseed did not start the seeding sequence");

   a_last_store_idles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) && (idx_ff == LAST_WORD) |=> state_ff == ST_IDLE)
      else $error("seeding did not end after the fourth word");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("request taken while seeding");

   a_rsp_from_next: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept && (req_cmd == CMD_NEXT)))
      else $error("response raised without a next request");

endmodule

// ----- rtl/core/xoshiro256ss_with_splitmix_seed.sv -----
// Channel | Ports      | Payload
// --------+------------+-----------------------------------------------
// request | req_t*     | tuser: cmd (0 reseed, 1 next); tdata: seed
// result  | rsp_t*     | tdata: random_word (xoshiro256** output)
//
// A next request needs no sequencing: the output word and the state update are
// xors, rotates and shift-add multiplies, and the word lands in the result
// register, so back-to-back next requests stream at one per cycle unless
// the result channel stalls. A reseed runs four splitmix64 draws, one per
// word; each draw runs two 64-bit constant multiplies through one shared
// 32 x 32 multiplier, three partial products each. Reseeds give no result.
// Reset (synchronous, active high) clears the four generator words and the
// splitmix64 counter. A request is refused while seeding, and any request
// waits while a result is held and the result channel is stalled.
module xoshiro256ss_with_splitmix_seed
   import xss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [WORD_W-1:0] req_tdata,   // [63:0] seed
   input  logic              req_tuser,   // [0] cmd
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [WORD_W-1:0] rsp_tdata    // [63:0] random_word
);

   dp_cmd_type cmd;

   // sequence reseeds and gate the handshakes
   xss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // hold generator state, counter, multiplier and result register
   xss_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .seed     (req_tdata),
      .rsp_data (rsp_tdata)
   );

endmodule
